@@ hdl/linear_blend_vertex_skinning_top_defines.svh @@
// assertion macros shared by the skinning block
`ifndef LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_TOP_DEFINES_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define LBVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define LBVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lbvs_pkg.sv @@
// types, constants and helpers of the vertex skinning block
package lbvs_pkg;

  localparam int JOINTS      = 64;
  localparam int FRAC_BITS   = 16;
  localparam int WORDS       = 12;
  localparam int WEIGHT_FRAC = 15;
  localparam int QDEPTH      = 4;
  localparam int INFL        = 4;

  localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_SKIN = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_ERR = 2'd2
  } status_e;

  // raw input word as unpacked from the stream
  typedef struct packed {
    func_e            func;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] nrm;
    logic [31:0]      joint_ids;
    logic [63:0]      blend_weights;
    logic [5:0]       load_joint;
    logic [3:0]       load_elem;
    logic [31:0]      load_value;
  } in_raw_t;

  // classified word held in the queue
  typedef struct packed {
    logic                         is_vtx;
    logic                         load_ok;
    logic                         err;
    logic [JIDX_W-1:0]            load_joint;
    logic [3:0]                   load_elem;
    logic [31:0]                  load_value;
    logic [2:0][31:0]             pos;
    logic [2:0][31:0]             nrm;
    logic [INFL-1:0][JIDX_W-1:0]  jid;
    logic [INFL-1:0][15:0]        wgt;
  } q_item_t;

  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;

  // clip to signed 32 bits, msb of the result flags a clip
  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > S32_MAX) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < S32_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

@@ hdl/linear_blend_vertex_skinning_top.sv @@
// top level of the four-influence vertex skinning block
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   pos xyz, nrm xyz, joint_ids, weights,   func
//                load_joint, load_elem, load_value
//  m_axis   out  skin_pos xyz, skin_nrm xyz              status
//
// a palette load word issues alone; a vertex issues once per influence, set
// by the twelve palette banks read at one joint a cycle while the pipe moves.
// a vertex result passes stages a to f, then the result register.
// a four-word queue takes input while the datapath works or waits.
// the whole datapath holds while a result is not taken. no clearing pass:
// palette words read before they are written give undefined results.
module linear_blend_vertex_skinning_top import lbvs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, joint_ids, blend_weights,
  // load_joint, load_elem, load_value, zero pad
  input  logic [335:0] s_axis_tdata_i,
  // func
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x, skin_nrm_y, skin_nrm_z
  output logic [191:0] m_axis_tdata_o,
  // status
  output logic [1:0]   m_axis_tuser_o
);

  in_raw_t          raw;
  logic             head_vld, pop;
  q_item_t          head;
  logic [2:0][31:0] out_pos, out_nrm;
  status_e          out_status;

  // unpack the input word
  always_comb begin
    raw.func          = func_e'(s_axis_tuser_i);
    raw.pos[0]        = s_axis_tdata_i[31:0];
    raw.pos[1]        = s_axis_tdata_i[63:32];
    raw.pos[2]        = s_axis_tdata_i[95:64];
    raw.nrm[0]        = s_axis_tdata_i[127:96];
    raw.nrm[1]        = s_axis_tdata_i[159:128];
    raw.nrm[2]        = s_axis_tdata_i[191:160];
    raw.joint_ids     = s_axis_tdata_i[223:192];
    raw.blend_weights = s_axis_tdata_i[287:224];
    raw.load_joint    = s_axis_tdata_i[293:288];
    raw.load_elem     = s_axis_tdata_i[297:294];
    raw.load_value    = s_axis_tdata_i[329:298];
  end

  lbvs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (s_axis_tvalid_i),
    .in_rdy_o   (s_axis_tready_o),
    .in_raw_i   (raw),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  lbvs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_vld_i      (head_vld),
    .q_item_i     (head),
    .q_pop_o      (pop),
    .out_vld_o    (m_axis_tvalid_o),
    .out_rdy_i    (m_axis_tready_i),
    .out_pos_o    (out_pos),
    .out_nrm_o    (out_nrm),
    .out_status_o (out_status)
  );

  // pack the result word
  assign m_axis_tdata_o = {out_nrm[2], out_nrm[1], out_nrm[0],
                           out_pos[2], out_pos[1], out_pos[0]};
  assign m_axis_tuser_o = out_status;

endmodule

@@ hdl/lbvs_front.sv @@
// input side: classifies words and queues them for the datapath
`include "linear_blend_vertex_skinning_top_defines.svh"

module lbvs_front import lbvs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_vld_i,
  output logic    in_rdy_o,
  input  in_raw_t in_raw_i,
  output logic    head_vld_o,
  output q_item_t head_o,
  input  logic    pop_i
);

  q_item_t           cls;
  q_item_t           fifo_q [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;
  logic [7:0]        lj8;
  logic [7:0]        jid8 [INFL];
  logic              any_bad;

  // classify: joint range check, load address check, field split
  always_comb begin
    any_bad = 1'b0;
    for (int k = 0; k < INFL; k++) begin
      jid8[k] = in_raw_i.joint_ids[8*k +: 8];
      if ({1'b0, jid8[k]} >= 9'(JOINTS)) begin
        any_bad = 1'b1;
      end
    end
    lj8            = {2'b00, in_raw_i.load_joint};
    cls.is_vtx     = (in_raw_i.func == FUNC_SKIN);
    cls.err        = any_bad;
    cls.load_ok    = ({1'b0, lj8} < 9'(JOINTS)) && (in_raw_i.load_elem < 4'(WORDS));
    cls.load_joint = lj8[JIDX_W-1:0];
    cls.load_elem  = in_raw_i.load_elem;
    cls.load_value = in_raw_i.load_value;
    cls.pos        = in_raw_i.pos;
    cls.nrm        = in_raw_i.nrm;
    for (int k = 0; k < INFL; k++) begin
      cls.jid[k] = jid8[k][JIDX_W-1:0];
      cls.wgt[k] = in_raw_i.blend_weights[16*k +: 16];
    end
  end

  assign in_rdy_o   = (count_q != QCNT_W'(QDEPTH));
  assign head_vld_o = (count_q != '0);
  assign head_o     = fifo_q[rd_ptr_q];
  assign push       = in_vld_i & in_rdy_o;
  assign pop        = pop_i & head_vld_o;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QIDX_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QIDX_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  `LBVS_ASSERT_NOW(a_cnt_max, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue overfilled")
  `LBVS_ASSERT_NEXT(a_cnt_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1), "count up")
  `LBVS_ASSERT_NEXT(a_cnt_dn, pop && !push, count_q == $past(count_q) - QCNT_W'(1), "count down")

endmodule

@@ hdl/lbvs_back.sv @@
// datapath: palette banks, per-joint transform, weighted blend, result register
`include "linear_blend_vertex_skinning_top_defines.svh"

module lbvs_back import lbvs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_vld_i,
  input  q_item_t          q_item_i,
  output logic             q_pop_o,
  output logic             out_vld_o,
  input  logic             out_rdy_i,
  output logic [2:0][31:0] out_pos_o,
  output logic [2:0][31:0] out_nrm_o,
  output status_e          out_status_o
);

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic err;
  } side_t;

  localparam logic signed [67:0] RND_T = 68'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [67:0] RND_W = 68'sd1 <<< (WEIGHT_FRAC - 1);

  logic              adv, issue_vtx, issue_ld;
  logic [1:0]        k_q;
  logic [JIDX_W-1:0] rd_addr;

  logic [31:0]        pal_mem [WORDS][JOINTS];
  logic signed [31:0] rd_q [WORDS];

  side_t              a_side_q, b_side_q, c_side_q, d_side_q, e_side_q, f_side_q;
  logic signed [31:0] a_pos_q [3];
  logic signed [31:0] a_nrm_q [3];
  logic [15:0]        a_w_q, b_w_q, c_w_q, d_w_q;
  logic signed [63:0] bp_q [3][3];
  logic signed [63:0] bn_q [3][3];
  logic signed [31:0] b_m3_q [3];
  logic signed [31:0] c_m3_q [3];
  logic signed [65:0] c_sp_q [3];
  logic signed [65:0] c_sn_q [3];
  logic signed [31:0] d_t_q [6];
  logic               d_sat_q, e_sat_q, f_sat_q;
  logic signed [48:0] e_tw_q [6];
  logic signed [50:0] f_acc_q [6];

  logic signed [67:0] rt [6];
  logic [32:0]        st [6];
  logic               st_any;
  logic signed [67:0] rb [6];
  logic [32:0]        sb [6];
  logic               sb_any;

  logic             out_vld_q;
  logic [2:0][31:0] out_pos_q, out_nrm_q;
  status_e          out_status_q;

  // whole pipe moves unless a finished result is waiting
  assign adv       = !out_vld_q || out_rdy_i;
  assign issue_vtx = adv && q_vld_i && q_item_i.is_vtx;
  assign issue_ld  = adv && q_vld_i && !q_item_i.is_vtx;
  assign q_pop_o   = issue_ld || (issue_vtx && (k_q == 2'd3));
  assign rd_addr   = q_item_i.jid[k_q];

  // influence counter, one joint per cycle while a vertex issues
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 2'd0;
    end else if (issue_vtx) begin
      k_q <= k_q + 2'd1;
    end
  end

  // palette banks, one per matrix element, all read at the same joint
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < WORDS; e++) begin
      if (issue_ld && q_item_i.load_ok && (q_item_i.load_elem == 4'(e))) begin
        pal_mem[e][q_item_i.load_joint] <= q_item_i.load_value;
      end
      if (adv) begin
        rd_q[e] <= pal_mem[e][rd_addr];
      end
    end
  end

  // control of the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
      b_side_q <= '0;
      c_side_q <= '0;
      d_side_q <= '0;
      e_side_q <= '0;
      f_side_q <= '0;
    end else if (adv) begin
      a_side_q <= '{vld: issue_vtx, first: (k_q == 2'd0), last: (k_q == 2'd3),
                    err: q_item_i.err};
      b_side_q <= a_side_q;
      c_side_q <= b_side_q;
      d_side_q <= c_side_q;
      e_side_q <= d_side_q;
      f_side_q <= e_side_q;
    end
  end

  // stage a: vertex operands beside the palette read
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        a_pos_q[c] <= q_item_i.pos[c];
        a_nrm_q[c] <= q_item_i.nrm[c];
      end
      a_w_q <= q_item_i.wgt[k_q];
    end
  end

  // stage b: matrix by vector products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          bp_q[r][c] <= rd_q[r*4+c] * a_pos_q[c];
          bn_q[r][c] <= rd_q[r*4+c] * a_nrm_q[c];
        end
        b_m3_q[r] <= rd_q[r*4+3];
      end
      b_w_q <= a_w_q;
    end
  end

  // stage c: exact row sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        c_sp_q[r] <= 66'(bp_q[r][0]) + 66'(bp_q[r][1]) + 66'(bp_q[r][2]);
        c_sn_q[r] <= 66'(bn_q[r][0]) + 66'(bn_q[r][1]) + 66'(bn_q[r][2]);
        c_m3_q[r] <= b_m3_q[r];
      end
      c_w_q <= b_w_q;
    end
  end

  // round half up to the fraction, add translation to positions, clip
  always_comb begin
    st_any = 1'b0;
    for (int r = 0; r < 3; r++) begin
      rt[r]   = ((68'(c_sp_q[r]) + RND_T) >>> FRAC_BITS) + 68'(c_m3_q[r]);
      rt[r+3] = (68'(c_sn_q[r]) + RND_T) >>> FRAC_BITS;
    end
    for (int j = 0; j < 6; j++) begin
      st[j]  = sat32(rt[j]);
      st_any = st_any | st[j][32];
    end
  end

  // stage d: per-joint transformed values
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        d_t_q[j] <= st[j][31:0];
      end
      d_sat_q <= st_any;
      d_w_q   <= c_w_q;
    end
  end

  // stage e: weight products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 6; j++) begin
        e_tw_q[j] <= d_t_q[j] * $signed({1'b0, d_w_q});
      end
      e_sat_q <= d_sat_q;
    end
  end

  // stage f: blend accumulators over the four influences
  always_ff @(posedge clk_i) begin
    if (adv && e_side_q.vld) begin
      for (int j = 0; j < 6; j++) begin
        f_acc_q[j] <= e_side_q.first ? 51'(e_tw_q[j]) : f_acc_q[j] + 51'(e_tw_q[j]);
      end
      f_sat_q <= e_side_q.first ? e_sat_q : (f_sat_q | e_sat_q);
    end
  end

  // final rounding from the weight fraction
  always_comb begin
    sb_any = 1'b0;
    for (int j = 0; j < 6; j++) begin
      rb[j]  = (68'(f_acc_q[j]) + RND_W) >>> WEIGHT_FRAC;
      sb[j]  = sat32(rb[j]);
      sb_any = sb_any | sb[j][32];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= f_side_q.vld && f_side_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && f_side_q.vld && f_side_q.last) begin
      for (int r = 0; r < 3; r++) begin
        out_pos_q[r] <= f_side_q.err ? 32'd0 : sb[r][31:0];
        out_nrm_q[r] <= f_side_q.err ? 32'd0 : sb[r+3][31:0];
      end
      if (f_side_q.err) begin
        out_status_q <= ST_ERR;
      end else if (f_sat_q || sb_any) begin
        out_status_q <= ST_SAT;
      end else begin
        out_status_q <= ST_OK;
      end
    end
  end

  assign out_vld_o    = out_vld_q;
  assign out_pos_o    = out_pos_q;
  assign out_nrm_o    = out_nrm_q;
  assign out_status_o = out_status_q;

  `LBVS_ASSERT_NEXT(a_stall_hold, out_vld_q && !out_rdy_i, $stable(k_q), "issue moved in stall")
  `LBVS_ASSERT_NOW(a_mid_vtx, k_q != 2'd0, q_vld_i && q_item_i.is_vtx, "head lost mid vertex")
  `LBVS_ASSERT_NOW(a_err_zero, out_vld_q && out_status_q == ST_ERR,
    out_pos_q == '0 && out_nrm_q == '0, "error result not zero")

endmodule

@@ sim/lbvs_skin_checker.sv @@
// checker for the skinning block: palette shadow, result prediction and compare
module lbvs_skin_checker import lbvs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [335:0] s_data_i,
  input  logic         s_user_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [191:0] m_data_i,
  input  logic [1:0]   m_user_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] coord [6];
    status_e            st;
  } skin_result_t;

  logic signed [31:0] palette_shadow [JOINTS*WORDS];
  skin_result_t       expected_skins [$];

  // clip to signed 32 bits and note the clip
  function automatic logic signed [31:0] clip32(input logic signed [67:0] v,
                                                inout bit clipped);
    if (v > 68'sd2147483647) begin
      clipped = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -68'sd2147483648) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // one matrix row times (x, y, z, homog), rounded half up
  function automatic logic signed [31:0] xform_row(input int base,
      input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z, input bit homog, inout bit clipped);
    logic signed [67:0] s;
    logic signed [67:0] t;
    s = 68'(palette_shadow[base]) * 68'(x) + 68'(palette_shadow[base+1]) * 68'(y)
      + 68'(palette_shadow[base+2]) * 68'(z);
    if (homog) begin
      t = palette_shadow[base+3];
      s = s + (t <<< FRAC_BITS);
    end
    s = (s + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clip32(s, clipped);
  endfunction

  function automatic skin_result_t predict_skin(input logic [335:0] d);
    skin_result_t       res;
    logic signed [67:0] acc [6];
    logic signed [16:0] wgt;
    logic signed [31:0] tp;
    logic signed [31:0] tn;
    logic [7:0]         jid;
    bit                 clipped;
    bit                 bad_id;
    int                 base;
    clipped = 1'b0;
    bad_id  = 1'b0;
    for (int k = 0; k < INFL; k++) begin
      if (d[192 + 8*k +: 8] >= JOINTS) bad_id = 1'b1;
    end
    if (bad_id) begin
      for (int j = 0; j < 6; j++) res.coord[j] = '0;
      res.st = ST_ERR;
      return res;
    end
    for (int j = 0; j < 6; j++) acc[j] = '0;
    for (int k = 0; k < INFL; k++) begin
      jid = d[192 + 8*k +: 8];
      wgt = {1'b0, d[224 + 16*k +: 16]};
      for (int r = 0; r < 3; r++) begin
        base = int'(jid) * WORDS + r * 4;
        tp = xform_row(base, d[31:0], d[63:32], d[95:64], 1'b1, clipped);
        tn = xform_row(base, d[127:96], d[159:128], d[191:160], 1'b0, clipped);
        acc[r]   = acc[r] + 68'(tp) * 68'(wgt);
        acc[r+3] = acc[r+3] + 68'(tn) * 68'(wgt);
      end
    end
    for (int j = 0; j < 6; j++) begin
      res.coord[j] = clip32((acc[j] + (68'sd1 <<< (WEIGHT_FRAC - 1))) >>> WEIGHT_FRAC,
                            clipped);
    end
    res.st = clipped ? ST_SAT : ST_OK;
    return res;
  endfunction

  // watch both channels at each edge
  always @(posedge clk_i) begin
    skin_result_t exp_r;
    logic [5:0]   lj;
    logic [3:0]   le;
    if (rst_ni) begin
      // accepted input word
      if (s_valid_i && s_ready_i) begin
        if (func_e'(s_user_i) == FUNC_SKIN) begin
          expected_skins.push_back(predict_skin(s_data_i));
        end else begin
          lj = s_data_i[293:288];
          le = s_data_i[297:294];
          if (le < WORDS && lj < JOINTS) palette_shadow[int'(lj)*WORDS + le] = s_data_i[329:298];
        end
      end
      // accepted result word
      if (m_valid_i && m_ready_i) begin
        if (expected_skins.size() == 0) begin
          $display("%0t: result word with nothing expected: data %h status %0d",
                   $time, m_data_i, m_user_i);
          fail_count_o++;
        end else begin
          exp_r = expected_skins.pop_front();
          for (int j = 0; j < 6; j++) begin
            if (m_data_i[32*j +: 32] !== exp_r.coord[j]) begin
              $display("%0t: coord %0d mismatch: expected %h actual %h",
                       $time, j, exp_r.coord[j], m_data_i[32*j +: 32]);
              fail_count_o++;
            end
          end
          if (m_user_i !== exp_r.st) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_r.st, m_user_i);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_skins.size();
    end
  end

endmodule

@@ sim/tb_linear_blend_vertex_skinning_top.sv @@
// testbench top: clock, reset, stimulus and verdict for the skinning block
module tb_linear_blend_vertex_skinning_top import lbvs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [335:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [191:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  bit written [JOINTS][WORDS];
  int full_joints [$];

  always #5 clk_i = ~clk_i;

  linear_blend_vertex_skinning_top u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  lbvs_skin_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid_i), .s_ready_i(s_axis_tready_o),
    .s_data_i(s_axis_tdata_i), .s_user_i(s_axis_tuser_i),
    .m_valid_i(m_axis_tvalid_o), .m_ready_i(m_axis_tready_i),
    .m_data_i(m_axis_tdata_o), .m_user_i(m_axis_tuser_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // run limit
  initial begin
    #3ms;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one word and wait for it to be taken, then maybe idle
  task automatic offer_word(input func_e fn, input logic [335:0] d);
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= fn;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic load_word(input int joint, input int elem, input logic [31:0] value);
    logic [335:0] d;
    bit           done;
    d = '0;
    d[293:288] = joint[5:0];
    d[297:294] = elem[3:0];
    d[329:298] = value;
    offer_word(FUNC_LOAD, d);
    if (elem < WORDS) begin
      written[joint][elem] = 1'b1;
      done = 1'b1;
      for (int e = 0; e < WORDS; e++) done &= written[joint][e];
      if (done && !(joint inside {full_joints})) full_joints.push_back(joint);
    end
  endtask

  task automatic skin_vertex(input logic [191:0] pn, input logic [31:0] ids,
                             input logic [63:0] wts);
    offer_word(FUNC_SKIN, {48'd0, wts, ids, pn});
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      2: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      3: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_ids();
    logic [31:0] ids;
    for (int k = 0; k < INFL; k++) begin
      ids[8*k +: 8] = 8'(full_joints[$urandom_range(full_joints.size() - 1)]);
    end
    // occasionally one index out of range
    if ($urandom_range(9) == 0) ids[8*$urandom_range(3) +: 8] = 8'($urandom_range(255, JOINTS));
    return ids;
  endfunction

  function automatic logic [63:0] rand_weights();
    logic [63:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(1)) begin
      for (int k = 0; k < INFL; k++) w[16*k +: 16] = 16'($urandom_range(16'h4000));
    end
    return w;
  endfunction

  task automatic random_items(input int count);
    logic [191:0] pn;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        load_word($urandom_range(JOINTS - 1), $urandom_range(15), rand_value());
      end else begin
        for (int j = 0; j < 6; j++) pn[32*j +: 32] = rand_value();
        skin_vertex(pn, rand_ids(), rand_weights());
      end
    end
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [191:0] pn;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity with translation on joint 0, extremes on joint 63
    for (int e = 0; e < WORDS; e++) begin
      load_word(0, e, (e % 5 == 0) ? 32'h0001_0000 : ((e % 4 == 3) ? 32'h0002_8000 : 32'h0));
    end
    for (int e = 0; e < WORDS; e++) begin
      load_word(63, e, e[0] ? 32'h8000_0000 : 32'h7fff_ffff);
    end
    // bad element indexes are dropped
    load_word(0, 12, 32'hffff_ffff);
    load_word(63, 15, 32'h0);

    pn = {32'hffff_8000, 32'h0000_8000, 32'h0001_0000, 32'hfffe_0000, 32'h0001_0000,
          32'h0000_4000};
    skin_vertex(pn, 32'h0, 64'h0000_0000_0000_8000);
    skin_vertex(pn, 32'h0, 64'hffff_ffff_ffff_ffff);
    skin_vertex({6{32'h7fff_ffff}}, 32'h3f3f_3f3f, 64'hffff_ffff_ffff_ffff);
    skin_vertex({6{32'h8000_0000}}, 32'h003f_003f, 64'h8000_0000_8000_0000);
    skin_vertex(pn, 32'h0000_4000, 64'h0000_0000_0000_8000);
    skin_vertex(pn, 32'hff00_0000, 64'h0);
    skin_vertex(pn, 32'h3f00_003f, 64'h0);
    wait_drained();

    // phase one: sender idles a little, receiver a lot
    tx_idle_pct = 15;
    rx_idle_pct = 77;
    random_items(200);
    // long receiver hold-off while words keep coming
    hold_req = 300;
    random_items(200);
    wait_drained();

    // phase two: the other way round
    tx_idle_pct = 77;
    rx_idle_pct = 15;
    random_items(420);

    // phase three: no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(420);

    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
